FILE: hw/rtl/efd_pkg.sv
// Shared types, codes and CRC helpers for the escaped frame decoder.
`timescale 1ns / 1ps
package efd_pkg;

  localparam logic [1:0] REG_START  = 2'd0;
  localparam logic [1:0] REG_END    = 2'd1;
  localparam logic [1:0] REG_ESCAPE = 2'd2;

  localparam logic [7:0] START_RESET  = 8'h01;
  localparam logic [7:0] END_RESET    = 8'h04;
  localparam logic [7:0] ESCAPE_RESET = 8'h10;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_CRC_BAD = 2'd1;
  localparam logic [1:0] ST_SHORT   = 2'd2;
  localparam logic [1:0] ST_OVERRUN = 2'd3;

  localparam logic [5:0] LEN_MAX = 6'd63;

  typedef enum logic [1:0] {
    CMD_DATA,
    CMD_END,
    CMD_OVR
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
  } cmd_t;

  localparam logic [15:0] NIB_TAB [16] = '{
    16'h0000, 16'h1021, 16'h2042, 16'h3063, 16'h4084, 16'h50a5, 16'h60c6, 16'h70e7,
    16'h8108, 16'h9129, 16'ha14a, 16'hb16b, 16'hc18c, 16'hd1ad, 16'he1ce, 16'hf1ef
  };

  function automatic logic [15:0] crc_nibble(logic [15:0] c, logic [3:0] nib);
    logic [3:0] k;
    k = c[15:12] ^ nib;
    return NIB_TAB[k] ^ {c[11:0], 4'h0};
  endfunction

  function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] t;
    t = crc_nibble(c, b[7:4]);
    return crc_nibble(t, b[3:0]);
  endfunction

endpackage

FILE: hw/rtl/efd_front.sv
// Front end: frame tracking, escape handling and command issue per raw item.
`timescale 1ns / 1ps
module efd_front #(
  parameter int MAX_RAW_FRAME = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    rx_byte_i,
  input  logic [7:0]    start_code_i,
  input  logic [7:0]    end_code_i,
  input  logic [7:0]    escape_code_i,
  output logic          push_o,
  output efd_pkg::cmd_t cmd_o
);
  import efd_pkg::*;

  localparam logic [6:0] RawLimit = 7'(MAX_RAW_FRAME - 1);

  logic       in_frame_q, in_frame_d;
  logic       esc_q, esc_d;
  logic [6:0] raw_q, raw_d;

  always_comb begin
    in_frame_d = in_frame_q;
    esc_d      = esc_q;
    raw_d      = raw_q;
    push_o     = 1'b0;
    cmd_o.kind = CMD_DATA;
    cmd_o.data = rx_byte_i;
    if (accept_i) begin
      if (!in_frame_q) begin
        if (rx_byte_i == start_code_i) begin
          in_frame_d = 1'b1;
          esc_d      = 1'b0;
          raw_d      = 7'd1;
        end
      end else if (!esc_q && rx_byte_i == end_code_i) begin
        push_o     = 1'b1;
        cmd_o.kind = CMD_END;
        in_frame_d = 1'b0;
        esc_d      = 1'b0;
        raw_d      = '0;
      end else if (raw_q >= RawLimit) begin
        push_o     = 1'b1;
        cmd_o.kind = CMD_OVR;
        in_frame_d = 1'b0;
        esc_d      = 1'b0;
        raw_d      = '0;
      end else begin
        raw_d = raw_q + 7'd1;
        if (!esc_q && rx_byte_i == escape_code_i) begin
          esc_d = 1'b1;
        end else begin
          esc_d  = 1'b0;
          push_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      esc_q      <= 1'b0;
      raw_q      <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      esc_q      <= esc_d;
      raw_q      <= raw_d;
    end
  end

endmodule

FILE: hw/rtl/efd_cmd_fifo.sv
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps
module efd_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  efd_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output efd_pkg::cmd_t cmd_o,
  output logic          empty_o,
  output logic          full_o
);
  import efd_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign empty_o = (count_q == 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) count_d = count_q + 2'd1;
    else if (!push_i && pop_i) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_d;
    end
  end

endmodule

FILE: hw/rtl/efd_back.sv
// Back end: two-byte CRC hold, running CRC, length count and output register.
`timescale 1ns / 1ps
module efd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          avail_i,
  input  efd_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          result_kind_o,
  output logic [7:0]    payload_byte_o,
  output logic [1:0]    frame_status_o,
  output logic [5:0]    payload_length_o
);
  import efd_pkg::*;

  logic [7:0]  hold0_q, hold0_d, hold1_q, hold1_d;
  logic [1:0]  fill_q, fill_d;
  logic [15:0] crc_q, crc_d;
  logic [5:0]  count_q, count_d;

  logic        vld_q, vld_d;
  logic        kind_q, kind_d;
  logic [7:0]  byte_q, byte_d;
  logic [1:0]  status_q, status_d;
  logic [5:0]  len_q, len_d;

  assign pop_o = avail_i && (!vld_q || out_ready_i);

  always_comb begin
    hold0_d  = hold0_q;
    hold1_d  = hold1_q;
    fill_d   = fill_q;
    crc_d    = crc_q;
    count_d  = count_q;
    vld_d    = vld_q && !out_ready_i;
    kind_d   = kind_q;
    byte_d   = byte_q;
    status_d = status_q;
    len_d    = len_q;
    if (pop_o) begin
      unique case (cmd_i.kind)
        CMD_DATA: begin
          if (fill_q == 2'd0) begin
            hold0_d = cmd_i.data;
            fill_d  = 2'd1;
          end else if (fill_q == 2'd1) begin
            hold1_d = cmd_i.data;
            fill_d  = 2'd2;
          end else begin
            hold0_d  = hold1_q;
            hold1_d  = cmd_i.data;
            crc_d    = crc_byte(crc_q, hold0_q);
            if (count_q != LEN_MAX) count_d = count_q + 6'd1;
            vld_d    = 1'b1;
            kind_d   = KIND_PAYLOAD;
            byte_d   = hold0_q;
            status_d = ST_GOOD;
            len_d    = '0;
          end
        end
        CMD_END, CMD_OVR: begin
          vld_d  = 1'b1;
          kind_d = KIND_REPORT;
          byte_d = '0;
          len_d  = count_q;
          if (cmd_i.kind == CMD_OVR) begin
            status_d = ST_OVERRUN;
          end else if (fill_q != 2'd2) begin
            status_d = ST_SHORT;
            len_d    = '0;
          end else if ({hold1_q, hold0_q} == crc_q) begin
            status_d = ST_GOOD;
          end else begin
            status_d = ST_CRC_BAD;
          end
          hold0_d = '0;
          hold1_d = '0;
          fill_d  = '0;
          crc_d   = '0;
          count_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold0_q <= '0;
      hold1_q <= '0;
      fill_q  <= '0;
      crc_q   <= '0;
      count_q <= '0;
      vld_q   <= 1'b0;
    end else begin
      hold0_q <= hold0_d;
      hold1_q <= hold1_d;
      fill_q  <= fill_d;
      crc_q   <= crc_d;
      count_q <= count_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    byte_q   <= byte_d;
    status_q <= status_d;
    len_q    <= len_d;
  end

  assign out_valid_o      = vld_q;
  assign result_kind_o    = kind_q;
  assign payload_byte_o   = byte_q;
  assign frame_status_o   = status_q;
  assign payload_length_o = len_q;

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != 2'd3)
    else $error("hold fill out of range");

  a_report_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && (cmd_i.kind == CMD_END || cmd_i.kind == CMD_OVR))
      |=> (fill_q == 2'd0 && count_q == 6'd0 && crc_q == 16'd0))
    else $error("frame state not cleared after report");

  a_payload_needs_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && cmd_i.kind == CMD_DATA && fill_q != 2'd2) |=> !vld_q)
    else $error("payload emitted before hold filled");

  a_payload_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && kind_q == KIND_PAYLOAD) |-> (status_q == ST_GOOD && len_q == 6'd0))
    else $error("payload item carries report fields");
`endif

endmodule

FILE: hw/rtl/escaped_frame_decoder_crc16_top.sv
// Top level of the escaped frame decoder with CRC-16 check.
`timescale 1ns / 1ps
// Usage:
//   s_axis: one raw link byte per item in s_axis_tdata_i[7:0].
//   m_axis: one result per item. tuser = result_kind (0 payload byte,
//     1 end of frame report); tdata = payload_byte, frame_status, payload_length.
//   APB: start code at 0x0, end code at 0x4, escape code at 0x8; write only
//     while the block is idle. pready is always high.
//   Payload bytes leave two bytes behind the input (the CRC hold) and are
//   emitted before the frame check; the report follows the end code.
// Timing:
//   Throughput one item per cycle while m_axis_tready_i keeps the output moving.
//   A result reaches the output register through a two-entry command queue that
//   separates the classifying front end from the CRC back end.
// Reset: codes return to 0x01/0x04/0x10, the decoder is idle, queue and
//   output register empty.
// Stall: when m_axis_tready_i is low the output register holds; the queue
//   absorbs two more commands, then s_axis_tready_o drops.
module escaped_frame_decoder_crc16_top #(
  parameter int MAX_RAW_FRAME = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] payload_byte, [9:8] frame_status,
                                        // [15:10] payload_length
  output logic [0:0]  m_axis_tuser_o,   // [0] result_kind
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  import efd_pkg::*;

  logic [7:0] start_q, end_q, escape_q;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  logic       accept, push, pop, empty, full;
  cmd_t       front_cmd, fifo_cmd;

  logic       kind;
  logic [7:0] payload_byte;
  logic [1:0] frame_status;
  logic [5:0] payload_length;

  assign pready_o = 1'b1;
  assign reg_idx  = paddr_i[3:2];
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= START_RESET;
      end_q    <= END_RESET;
      escape_q <= ESCAPE_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_START:  start_q  <= pwdata_i[7:0];
        REG_END:    end_q    <= pwdata_i[7:0];
        REG_ESCAPE: escape_q <= pwdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START:  prdata_o = {24'd0, start_q};
      REG_END:    prdata_o = {24'd0, end_q};
      REG_ESCAPE: prdata_o = {24'd0, escape_q};
      default:    prdata_o = '0;
    endcase
  end

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && !full;

  efd_front #(
    .MAX_RAW_FRAME(MAX_RAW_FRAME)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .rx_byte_i     (s_axis_tdata_i),
    .start_code_i  (start_q),
    .end_code_i    (end_q),
    .escape_code_i (escape_q),
    .push_o        (push),
    .cmd_o         (front_cmd)
  );

  efd_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .cmd_o   (fifo_cmd),
    .empty_o (empty),
    .full_o  (full)
  );

  efd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .avail_i          (!empty),
    .cmd_i            (fifo_cmd),
    .pop_o            (pop),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .result_kind_o    (kind),
    .payload_byte_o   (payload_byte),
    .frame_status_o   (frame_status),
    .payload_length_o (payload_length)
  );

  assign m_axis_tuser_o = kind;
  assign m_axis_tdata_o = {payload_length, frame_status, payload_byte};

endmodule
